// ===== rtl/sis_pkg.sv =====
// Shared types, codes and constant tables for the status indicator sequencer.
package sis_pkg;

	typedef enum logic [1:0] {
		OP_TICK = 2'd0,
		OP_BEEP = 2'd1,
		OP_TUNE = 2'd2
	} sis_op_t;

	localparam logic signed [1:0] FORCE_AUTO = 2'sb00;
	localparam logic signed [1:0] FORCE_ON   = 2'sb01;
	localparam logic signed [1:0] FORCE_OFF  = 2'sb11;

	localparam int NOTE_COUNT = 7;
	localparam logic [10:0] BEEP_HZ = 11'd2000;

	localparam logic [5:0] LVL_FULL     = 6'd50;
	localparam logic [5:0] LVL_UPLOAD_G = 6'd40;
	localparam logic [5:0] LVL_NOFIX_G  = 6'd10;
	localparam logic [5:0] LVL_NOFIX_B  = 6'd40;

	typedef struct packed {
		logic [5:0] r;
		logic [5:0] g;
		logic [5:0] b;
	} color_t;

	// per-beat command strobes into the sound unit
	typedef struct packed {
		logic tick;
		logic beep;
		logic tune;
	} sis_cmd_t;

	// sound unit status after the beat has been applied
	typedef struct packed {
		logic [10:0] tone_hz;
		logic        beep_busy;
		logic        tune_busy;
	} sis_snd_t;

	function automatic logic [10:0] note_hz(input logic [2:0] slot);
		logic [10:0] hz;
		case (slot)
			3'd0:    hz = 11'd523;
			3'd1:    hz = 11'd659;
			3'd2:    hz = 11'd784;
			3'd3:    hz = 11'd1047;
			3'd4:    hz = 11'd988;
			3'd5:    hz = 11'd784;
			default: hz = 11'd1047;
		endcase
		return hz;
	endfunction

	function automatic logic [8:0] note_ticks(input logic [2:0] slot);
		logic [8:0] t;
		case (slot)
			3'd0:    t = 9'd150;
			3'd1:    t = 9'd150;
			3'd2:    t = 9'd150;
			3'd3:    t = 9'd180;
			3'd4:    t = 9'd130;
			3'd5:    t = 9'd130;
			default: t = 9'd400;
		endcase
		return t;
	endfunction

endpackage

// ===== rtl/sis_if.sv =====
// Valid/ready channel interfaces for the request and response streams.
interface sis_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic        uploading_backlog;
	logic        network_up;
	logic        server_up;
	logic        gps_fix;
	logic [7:0]  beep_times;
	logic [15:0] beep_length_ms;

	modport source (
		output valid, op, uploading_backlog, network_up, server_up, gps_fix,
		       beep_times, beep_length_ms,
		input  ready
	);
	modport sink (
		input  valid, op, uploading_backlog, network_up, server_up, gps_fix,
		       beep_times, beep_length_ms,
		output ready
	);
endinterface

interface sis_rsp_if;
	logic        valid;
	logic        ready;
	logic [5:0]  red;
	logic [5:0]  green;
	logic [5:0]  blue;
	logic        led_level;
	logic [10:0] tone_hz;
	logic        beep_busy;
	logic        tune_busy;

	modport source (
		output valid, red, green, blue, led_level, tone_hz, beep_busy, tune_busy,
		input  ready
	);
	modport sink (
		input  valid, red, green, blue, led_level, tone_hz, beep_busy, tune_busy,
		output ready
	);
endinterface

// ===== rtl/sis_sound.sv =====
// Beep sequencer and startup tune player, with tone selection.
module sis_sound #(
	parameter int TUNE_STEPS = 7
) (
	input  logic                clk,
	input  logic                arst_n,
	input  sis_pkg::sis_cmd_t   cmd,
	input  logic [7:0]          beep_times,
	input  logic [15:0]         beep_length_ms,
	output sis_pkg::sis_snd_t   snd
);

	localparam int TIW = $clog2(TUNE_STEPS + 1);

	logic [7:0]     beeps_wanted_q, beeps_wanted_n;
	logic [7:0]     beeps_done_q, beeps_done_n;
	logic [15:0]    beep_length_q, beep_length_n;
	logic           beep_sounding_q, beep_sounding_n;
	logic [15:0]    beep_elapsed_q, beep_elapsed_n;
	logic           tune_running_q, tune_running_n;
	logic [TIW-1:0] tune_index_q, tune_index_n;
	logic           note_sounding_q, note_sounding_n;
	logic [8:0]     note_elapsed_q, note_elapsed_n;

	logic [2:0]     slot_cur, slot_nxt;
	logic [TIW-1:0] index_inc;
	logic [8:0]     note_inc;
	logic [15:0]    beep_inc;
	logic [7:0]     done_inc;

	// notes past the end of the table reuse the last one
	always_comb begin
		slot_cur = (32'(tune_index_q) < sis_pkg::NOTE_COUNT) ?
			3'(tune_index_q) : 3'(sis_pkg::NOTE_COUNT - 1);
		slot_nxt = (32'(tune_index_n) < sis_pkg::NOTE_COUNT) ?
			3'(tune_index_n) : 3'(sis_pkg::NOTE_COUNT - 1);
	end

	always_comb begin
		beeps_wanted_n  = beeps_wanted_q;
		beeps_done_n    = beeps_done_q;
		beep_length_n   = beep_length_q;
		beep_sounding_n = beep_sounding_q;
		beep_elapsed_n  = beep_elapsed_q;
		tune_running_n  = tune_running_q;
		tune_index_n    = tune_index_q;
		note_sounding_n = note_sounding_q;
		note_elapsed_n  = note_elapsed_q;

		beep_inc  = (beep_elapsed_q != 16'hFFFF) ? beep_elapsed_q + 16'd1 : beep_elapsed_q;
		done_inc  = beeps_done_q + 8'd1;
		note_inc  = note_elapsed_q + 9'd1;
		index_inc = tune_index_q + TIW'(1);

		if (cmd.tick) begin
			if (beeps_wanted_q != 8'd0) begin
				if (!beep_sounding_q) begin
					if (beep_elapsed_q >= beep_length_q) begin
						beep_sounding_n = 1'b1;
						beep_elapsed_n  = 16'd0;
					end else begin
						beep_elapsed_n = beep_elapsed_q + 16'd1;
					end
				end else begin
					beep_elapsed_n = beep_inc;
					if (beep_inc >= beep_length_q) begin
						beep_sounding_n = 1'b0;
						beep_elapsed_n  = 16'd1;
						beeps_done_n    = done_inc;
						if (done_inc >= beeps_wanted_q)
							beeps_wanted_n = 8'd0;
					end
				end
			end
			if (tune_running_q) begin
				if (!note_sounding_q) begin
					note_sounding_n = 1'b1;
					note_elapsed_n  = 9'd0;
				end else begin
					note_elapsed_n = note_inc;
					if (note_inc >= sis_pkg::note_ticks(slot_cur)) begin
						note_sounding_n = 1'b0;
						note_elapsed_n  = 9'd0;
						tune_index_n    = index_inc;
						if (32'(index_inc) >= TUNE_STEPS) begin
							tune_running_n = 1'b0;
							tune_index_n   = '0;
						end
					end
				end
			end
		end

		// a request while a beep is running is dropped
		if (cmd.beep && beeps_wanted_q == 8'd0) begin
			beeps_wanted_n  = beep_times;
			beeps_done_n    = 8'd0;
			beep_length_n   = beep_length_ms;
			beep_sounding_n = 1'b0;
			beep_elapsed_n  = beep_length_ms;
		end

		if (cmd.tune) begin
			tune_running_n  = 1'b1;
			tune_index_n    = '0;
			note_sounding_n = 1'b0;
			note_elapsed_n  = 9'd0;
		end
	end

	always_comb begin
		if (tune_running_n && note_sounding_n)
			snd.tone_hz = sis_pkg::note_hz(slot_nxt);
		else if (beeps_wanted_n != 8'd0 && beep_sounding_n)
			snd.tone_hz = sis_pkg::BEEP_HZ;
		else
			snd.tone_hz = 11'd0;
		snd.beep_busy = (beeps_wanted_n != 8'd0);
		snd.tune_busy = tune_running_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beeps_wanted_q  <= '0;
			beeps_done_q    <= '0;
			beep_length_q   <= '0;
			beep_sounding_q <= 1'b0;
			beep_elapsed_q  <= '0;
			tune_running_q  <= 1'b0;
			tune_index_q    <= '0;
			note_sounding_q <= 1'b0;
			note_elapsed_q  <= '0;
		end else begin
			beeps_wanted_q  <= beeps_wanted_n;
			beeps_done_q    <= beeps_done_n;
			beep_length_q   <= beep_length_n;
			beep_sounding_q <= beep_sounding_n;
			beep_elapsed_q  <= beep_elapsed_n;
			tune_running_q  <= tune_running_n;
			tune_index_q    <= tune_index_n;
			note_sounding_q <= note_sounding_n;
			note_elapsed_q  <= note_elapsed_n;
		end
	end

endmodule

// ===== rtl/status_indicator_sequencer.sv =====
// Top level: input stage, blink/color/LED logic and response register.
//
//  channel  | modport      | payload
//  ---------+--------------+------------------------------------------------
//  req      | sis_req_if   | op, status flags, beep_times, beep_length_ms
//  rsp      | sis_rsp_if   | red, green, blue, led_level, tone_hz, busy flags
//  cfg      | wr_en/wr_data| led_force_mode (2-bit signed)
//
// One beat per cycle sustained while the response is not stalled; a beat passes
// through the input stage, then the response register. The state update for a
// beat is a single pass in the cycle it leaves the input stage. A stalled
// response holds the input stage, which still takes one more beat. Reset clears
// all state but the stage payloads; LED level resets to 1 (off), color to zero.
module status_indicator_sequencer #(
	parameter int BLINK_HALF_TICKS = 500,
	parameter int TUNE_STEPS       = 7
) (
	input  logic              clk,
	input  logic              arst_n,
	sis_req_if.sink           req,
	sis_rsp_if.source         rsp,
	input  logic              cfg_wr_en,
	input  logic signed [1:0] cfg_wr_data
);

	localparam int BTW = $clog2(BLINK_HALF_TICKS + 1);

	logic signed [1:0] force_mode_q;

	// input stage
	logic        valid_s1;
	logic [1:0]  op_s1;
	logic        uploading_s1, network_s1, server_s1, gps_s1;
	logic [7:0]  beep_times_s1;
	logic [15:0] beep_len_s1;

	logic advance;
	logic is_tick;

	logic           blink_phase_q, blink_phase_n;
	logic [BTW-1:0] blink_ticks_q, blink_ticks_n, blink_inc;
	sis_pkg::color_t last_color_q, color_n, color_pick;
	logic           led_held_q, led_n;
	logic           blinks;

	sis_pkg::sis_cmd_t cmd;
	sis_pkg::sis_snd_t snd;

	// response register
	logic            valid_s2;
	sis_pkg::color_t color_s2;
	logic            led_s2;
	sis_pkg::sis_snd_t snd_s2;

	assign advance   = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	always_comb begin
		cmd = '0;
		unique case (sis_pkg::sis_op_t'(op_s1))
			sis_pkg::OP_TICK: cmd.tick = advance;
			sis_pkg::OP_BEEP: cmd.beep = advance;
			sis_pkg::OP_TUNE: cmd.tune = advance;
			default:          cmd = '0;
		endcase
	end
	assign is_tick = cmd.tick;

	sis_sound #(.TUNE_STEPS(TUNE_STEPS)) u_sound (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.beep_times     (beep_times_s1),
		.beep_length_ms (beep_len_s1),
		.snd            (snd)
	);

	always_comb begin
		blink_inc     = blink_ticks_q + BTW'(1);
		blink_phase_n = blink_phase_q;
		blink_ticks_n = blink_ticks_q;
		color_n       = last_color_q;
		led_n         = led_held_q;

		if (uploading_s1) begin
			color_pick = '{sis_pkg::LVL_FULL, sis_pkg::LVL_UPLOAD_G, 6'd0};
			blinks     = 1'b1;
		end else if (!network_s1) begin
			color_pick = '{sis_pkg::LVL_FULL, 6'd0, 6'd0};
			blinks     = 1'b0;
		end else if (!server_s1) begin
			color_pick = '{6'd0, 6'd0, sis_pkg::LVL_FULL};
			blinks     = 1'b1;
		end else if (!gps_s1) begin
			color_pick = '{6'd0, sis_pkg::LVL_NOFIX_G, sis_pkg::LVL_NOFIX_B};
			blinks     = 1'b1;
		end else begin
			color_pick = '{6'd0, sis_pkg::LVL_FULL, 6'd0};
			blinks     = 1'b0;
		end

		if (is_tick) begin
			blink_ticks_n = blink_inc;
			if (32'(blink_inc) >= BLINK_HALF_TICKS) begin
				blink_phase_n = ~blink_phase_q;
				blink_ticks_n = '0;
			end
			// blinking colors go dark in the off half, using the new phase
			color_n = (blinks && !blink_phase_n) ? '0 : color_pick;
			if (force_mode_q == sis_pkg::FORCE_ON)
				led_n = 1'b0;
			else if (force_mode_q == sis_pkg::FORCE_OFF)
				led_n = 1'b1;
			else if (gps_s1)
				led_n = ~blink_phase_n;
			else
				led_n = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			force_mode_q  <= sis_pkg::FORCE_AUTO;
			valid_s1      <= 1'b0;
			valid_s2      <= 1'b0;
			blink_phase_q <= 1'b0;
			blink_ticks_q <= '0;
			last_color_q  <= '0;
			led_held_q    <= 1'b1;
		end else begin
			if (cfg_wr_en)
				force_mode_q <= cfg_wr_data;
			if (req.ready)
				valid_s1 <= req.valid;
			if (advance)
				valid_s2 <= 1'b1;
			else if (rsp.ready)
				valid_s2 <= 1'b0;
			blink_phase_q <= blink_phase_n;
			blink_ticks_q <= blink_ticks_n;
			last_color_q  <= color_n;
			led_held_q    <= led_n;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			op_s1         <= req.op;
			uploading_s1  <= req.uploading_backlog;
			network_s1    <= req.network_up;
			server_s1     <= req.server_up;
			gps_s1        <= req.gps_fix;
			beep_times_s1 <= req.beep_times;
			beep_len_s1   <= req.beep_length_ms;
		end
		if (advance) begin
			color_s2 <= color_n;
			led_s2   <= led_n;
			snd_s2   <= snd;
		end
	end

	assign rsp.valid     = valid_s2;
	assign rsp.red       = color_s2.r;
	assign rsp.green     = color_s2.g;
	assign rsp.blue      = color_s2.b;
	assign rsp.led_level = led_s2;
	assign rsp.tone_hz   = snd_s2.tone_hz;
	assign rsp.beep_busy = snd_s2.beep_busy;
	assign rsp.tune_busy = snd_s2.tune_busy;

`ifndef SYNTH
	// without a tune note only the beep pitch or silence can come out
	a_tone_src: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !snd_s2.tune_busy |->
			(snd_s2.tone_hz == 11'd0 || snd_s2.tone_hz == sis_pkg::BEEP_HZ))
		else $error("tone without a running tune is not beep or silence");

	a_silent_idle: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !snd_s2.tune_busy && !snd_s2.beep_busy |-> snd_s2.tone_hz == 11'd0)
		else $error("tone while beep and tune are idle");

	a_blink_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(blink_ticks_q) < BLINK_HALF_TICKS)
		else $error("blink counter out of range");

	// no status color mixes red and blue
	a_color_mix: assert property (@(posedge clk) disable iff (!arst_n)
		last_color_q.r != 6'd0 |-> last_color_q.b == 6'd0)
		else $error("illegal status color");
`endif

endmodule
